// ===== src/csg_pkg.sv =====
// shared constants, types and fixed-point helpers for the chaotic sequence generator
package csg_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int CELL_COUNT = 8;
    localparam int QW         = FRAC_BITS + 8;
    localparam int SW         = 15;
    localparam int PW         = 14;
    localparam int SCALE      = 10000;

    localparam longint ONE_L = longint'(1) << FRAC_BITS;

    // reciprocal multipliers for divisions by constants, rounded up
    localparam int     RECIP_K = 32;
    localparam int     SAMP_K  = 36;
    localparam longint M_RMAP  = ((longint'(9999) * ONE_L << RECIP_K) + 99999999) / 100000000;
    localparam longint M_RHEN  = ((longint'(4) * ONE_L << RECIP_K) + 99999) / 100000;
    localparam longint M_DER   = ((ONE_L << RECIP_K) + 9999) / 10000;
    localparam longint M_DERH  = ((longint'(3) * ONE_L << RECIP_K) + 19999) / 20000;
    localparam longint M_SAMPH = ((longint'(20000) << SAMP_K) + 3 * ONE_L - 1) / (3 * ONE_L);

    localparam logic signed [QW-1:0] ONE_Q  = QW'(ONE_L);
    localparam logic signed [QW-1:0] HALF_Q = QW'(ONE_L / 2);
    localparam logic signed [QW-1:0] B_Q    = QW'((3 * ONE_L) / 10);
    localparam logic signed [QW-1:0] HALF3  = QW'((3 * ONE_L) / 2);
    localparam logic signed [QW-1:0] Q_MAX  = {1'b0, {(QW-1){1'b1}}};
    localparam logic signed [QW-1:0] Q_MIN  = {1'b1, {(QW-1){1'b0}}};

    localparam logic [1:0] MODE_LOGISTIC = 2'd0;
    localparam logic [1:0] MODE_CUBIC    = 2'd1;
    localparam logic [1:0] MODE_HENON    = 2'd2;
    localparam logic [1:0] MODE_CELL     = 2'd3;

    localparam logic OP_STEP = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    localparam logic REG_MODE  = 1'b0;
    localparam logic REG_PARAM = 1'b1;

    typedef struct packed {
        logic signed [QW-1:0] wx;
        logic signed [SW-1:0] last;
    } t_derive;

    // saturate a wider signed value to the working width
    function automatic logic signed [QW-1:0] sat_q(input logic signed [QW+2:0] v);
        logic signed [QW+2:0] hi;
        logic signed [QW+2:0] lo;
        hi = (QW+3)'(Q_MAX);
        lo = (QW+3)'(Q_MIN);
        if (v > hi) return Q_MAX;
        if (v < lo) return Q_MIN;
        return v[QW-1:0];
    endfunction

endpackage

// ===== src/csg_qmul.sv =====
// shared fixed-point multiplier: sign-magnitude product truncated toward zero, saturated, registered
module csg_qmul import csg_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [QW-1:0] i_a,
    input  logic signed [QW-1:0] i_b,
    output logic signed [QW-1:0] o_p
);

    logic                   neg;
    logic [QW-1:0]          ma;
    logic [QW-1:0]          mb;
    logic [2*QW-1:0]        prod;
    logic [2*QW-FRAC_BITS-1:0] pm;
    logic signed [QW-1:0]   n_p;
    logic signed [QW-1:0]   r_p;

    always_comb begin
        neg  = i_a[QW-1] ^ i_b[QW-1];
        ma   = i_a[QW-1] ? (~i_a + QW'(1)) : i_a;
        mb   = i_b[QW-1] ? (~i_b + QW'(1)) : i_b;
        prod = (2*QW)'(ma) * (2*QW)'(mb);
        pm   = prod[2*QW-1:FRAC_BITS];
        if (pm > (2*QW-FRAC_BITS)'(Q_MAX)) begin
            n_p = neg ? Q_MIN : Q_MAX;
        end else begin
            n_p = neg ? -$signed(pm[QW-1:0]) : $signed(pm[QW-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= n_p;
        end
    end

    assign o_p = r_p;

endmodule

// ===== src/csg_cell.sv =====
// one generation of the wrapping elementary cellular automaton
module csg_cell import csg_pkg::*; (
    input  logic [CELL_COUNT-1:0] i_cells,
    input  logic [7:0]            i_rule,
    output logic [CELL_COUNT-1:0] o_cells
);

    for (genvar i = 0; i < CELL_COUNT; i++) begin : g_cell
        localparam int RN = (i == 0) ? CELL_COUNT - 1 : i - 1;
        localparam int LN = (i == CELL_COUNT - 1) ? 0 : i + 1;
        assign o_cells[i] = i_rule[{i_cells[LN], i_cells[i], i_cells[RN]}];
    end

endmodule

// ===== src/chaotic_sequence_generator_top.sv =====
// chaotic sequence generator: sequencer around one shared fixed-point multiplier
// load request: no result; the input is ready again the next cycle
// step request: cellular mode goes straight to the finish state; the map modes first pass
//   through the multiply state once per product (logistic 2, henon 3, cubic 4); one request at a time,
//   limited by the single multiplier that the map's dependent products share
// synchronous active-low reset: mode 0, param 5000, x = 0.5, previous x = 0, last = 5000
module chaotic_sequence_generator_top import csg_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_opcode,
    input  logic signed [SW-1:0] i_load_value,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic signed [SW-1:0] o_sample,
    input  logic                 i_psel,
    input  logic                 i_penable,
    input  logic                 i_pwrite,
    input  logic [2:0]           i_paddr,
    input  logic [31:0]          i_pwdata,
    output logic [31:0]          o_prdata,
    output logic                 o_pready
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]           r_state, n_state;
    logic [1:0]           r_step, n_step;
    logic [1:0]           r_mode;
    logic [PW-1:0]        r_param;
    logic signed [QW-1:0] r_wx, r_px, r_keep, r_rmap, r_rhen;
    logic signed [SW-1:0] r_last;
    logic signed [SW-1:0] r_sample;
    logic                 r_oval;

    logic                 in_acc, cfg_wr, out_free, mul_en;
    logic [PW-1:0]        psat;
    logic [63:0]          rm_prod, rh_prod;
    logic signed [QW-1:0] acc, op_a, op_b, x0, omx, omr, new_x;
    logic signed [QW+2:0] hn;
    logic [1:0]           last_step;
    logic signed [SW-1:0] load_sat, new_sample;
    logic [QW-1:0]        smag;
    logic [63:0]          sprod;
    logic [21:0]          squo;
    logic [CELL_COUNT-1:0] cells_next;
    logic [7:0]           rule;
    t_derive              drv;
    logic [1:0]           drv_mode;
    logic signed [SW-1:0] drv_lv;

    assign in_acc   = i_valid && !o_stall;
    assign cfg_wr   = i_psel && i_penable && i_pwrite && o_pready;
    assign out_free = !r_oval || !i_stall;
    assign o_stall  = (r_state != ST_IDLE);
    assign o_valid  = r_oval;
    assign o_sample = r_sample;
    assign o_pready = 1'b1;
    assign o_prdata = (i_paddr[2] == REG_PARAM) ? {{(32-PW){1'b0}}, r_param}
                                                 : {30'd0, r_mode};

    // map coefficients follow param through a register
    assign psat    = (r_param > PW'(SCALE)) ? PW'(SCALE) : r_param;
    assign rm_prod = 64'(psat) * 64'(M_RMAP);
    assign rh_prod = 64'(psat) * 64'(M_RHEN);
    assign rule    = (r_param > PW'(255)) ? 8'hff : r_param[7:0];

    csg_cell u_cell (
        .i_cells (r_last[CELL_COUNT-1:0]),
        .i_rule  (rule),
        .o_cells (cells_next)
    );

    // operand selection for the shared multiplier
    always_comb begin
        x0  = r_wx[QW-1] ? '0 : r_wx;
        omx = sat_q((QW+3)'(ONE_Q) - (QW+3)'(x0));
        omr = sat_q((QW+3)'(ONE_Q) - (QW+3)'(r_rmap));
        op_a = r_wx;
        op_b = r_wx;
        last_step = 2'd0;
        unique case (r_mode)
            MODE_LOGISTIC: begin
                last_step = 2'd1;
                op_a = (r_step == 2'd0) ? x0 : acc;
                op_b = (r_step == 2'd0) ? r_rmap : omx;
            end
            MODE_CUBIC: begin
                last_step = 2'd3;
                unique case (r_step)
                    2'd0: begin op_a = r_wx;   op_b = r_wx; end
                    2'd1: begin op_a = acc;    op_b = r_wx; end
                    2'd2: begin op_a = r_rmap; op_b = acc;  end
                    default: begin op_a = r_wx; op_b = omr; end
                endcase
            end
            MODE_HENON: begin
                last_step = 2'd2;
                unique case (r_step)
                    2'd0:    begin op_a = r_wx; op_b = r_wx;   end
                    2'd1:    begin op_a = acc;  op_b = r_rhen; end
                    default: begin op_a = B_Q;  op_b = r_px;   end
                endcase
            end
            default: last_step = 2'd0;
        endcase
    end

    assign mul_en = (r_state == ST_MUL);

    csg_qmul u_mul (
        .i_clk (i_clk),
        .i_en  (mul_en),
        .i_a   (op_a),
        .i_b   (op_b),
        .o_p   (acc)
    );

    // final value and sample
    always_comb begin
        hn = (QW+3)'(ONE_Q) - (QW+3)'(r_keep) + (QW+3)'(acc);
        if (hn < -(QW+3)'(HALF3)) hn = -(QW+3)'(HALF3) - hn;
        if (hn > (QW+3)'(HALF3))  hn = (QW+3)'(HALF3) - hn;
        unique case (r_mode)
            MODE_CUBIC: new_x = sat_q((QW+3)'(r_keep) + (QW+3)'(acc));
            MODE_HENON: new_x = sat_q(hn);
            default:    new_x = acc;
        endcase
        smag = new_x[QW-1] ? (~new_x + QW'(1)) : new_x;
        if (r_mode == MODE_HENON) begin
            sprod = 64'(smag) * 64'(M_SAMPH);
            squo  = sprod[SAMP_K +: 22];
        end else begin
            sprod = 64'(smag) * 64'(SCALE);
            squo  = sprod[FRAC_BITS +: 22];
        end
        if (squo > 22'(SCALE)) squo = 22'(SCALE);
        if (r_mode == MODE_CELL) begin
            new_sample = SW'(cells_next);
        end else begin
            new_sample = new_x[QW-1] ? -$signed(squo[SW-1:0]) : $signed(squo[SW-1:0]);
        end
    end

    // rebuild the working value from the load value or the last sample
    always_comb begin
        logic [PW-1:0] lmag;
        logic [63:0]   dprod;
        logic [QW-1:0] dq;
        if (i_load_value > SW'(SCALE)) begin
            load_sat = SW'(SCALE);
        end else if (i_load_value < -SW'(SCALE)) begin
            load_sat = -SW'(SCALE);
        end else begin
            load_sat = i_load_value;
        end
        drv_mode = (cfg_wr && i_paddr[2] == REG_MODE) ? i_pwdata[1:0] : r_mode;
        drv_lv   = in_acc ? load_sat : r_last;
        lmag  = drv_lv[SW-1] ? PW'(-drv_lv) : PW'(drv_lv);
        dprod = 64'(lmag) * ((drv_mode == MODE_HENON) ? 64'(M_DERH) : 64'(M_DER));
        dq    = dprod[RECIP_K +: QW];
        drv.wx   = r_wx;
        drv.last = drv_lv;
        if (drv_mode == MODE_CELL) begin
            if (drv_lv > SW'(255)) drv.last = SW'(255);
            if (drv_lv[SW-1])      drv.last = '0;
        end else begin
            drv.wx = drv_lv[SW-1] ? -$signed(dq) : $signed(dq);
        end
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        unique case (r_state)
            ST_IDLE: begin
                n_step = 2'd0;
                if (in_acc && i_opcode == OP_STEP) begin
                    n_state = (r_mode == MODE_CELL) ? ST_FIN : ST_MUL;
                end
            end
            ST_MUL: begin
                n_step = r_step + 2'd1;
                if (r_step == last_step) n_state = ST_FIN;
            end
            ST_FIN: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rmap <= QW'(3 * ONE_L) + QW'(rm_prod[RECIP_K +: QW]);
        r_rhen <= ONE_Q + QW'(rh_prod[RECIP_K +: QW]);
        if (mul_en) r_keep <= acc;
        if (r_state == ST_FIN && out_free) r_sample <= new_sample;
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= 2'd0;
            r_mode  <= MODE_LOGISTIC;
            r_param <= PW'(5000);
            r_wx    <= HALF_Q;
            r_px    <= '0;
            r_last  <= SW'(5000);
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            if (r_oval && !i_stall && !(r_state == ST_FIN && out_free)) r_oval <= 1'b0;
            if (cfg_wr) begin
                if (i_paddr[2] == REG_MODE) r_mode <= i_pwdata[1:0];
                else                        r_param <= i_pwdata[PW-1:0];
            end
            if (cfg_wr || (in_acc && i_opcode == OP_LOAD)) begin
                r_wx   <= drv.wx;
                r_last <= drv.last;
            end
            if (r_state == ST_FIN && out_free) begin
                r_oval <= 1'b1;
                r_last <= new_sample;
                if (r_mode != MODE_CELL) r_wx <= new_x;
                if (r_mode == MODE_HENON) r_px <= r_wx;
            end
        end
    end

endmodule

// ===== src/csg_checker.sv =====
// port-level checks for the chaotic sequence generator, bound to the top level
module csg_port_checker import csg_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_valid,
    input logic                 o_stall,
    input logic                 i_opcode,
    input logic                 o_valid,
    input logic                 i_stall,
    input logic signed [SW-1:0] o_sample,
    input logic                 o_pready
);

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n) o_pready)
        else $error("pready dropped");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_sample))
        else $error("stalled result changed");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_sample <= SW'(SCALE)) && (o_sample >= -SW'(SCALE)))
        else $error("sample out of range");

    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_opcode == OP_LOAD |=> !o_stall)
        else $error("load request blocked input");

    a_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_opcode == OP_STEP |=> o_stall)
        else $error("step request did not start work");

endmodule

bind chaotic_sequence_generator_top csg_port_checker u_csg_port_checker (.*);

// ===== tb/csg_checker.sv =====
// request/result monitor with a predictor of the chaotic sequence generator
`timescale 1ns / 1ps

module csg_checker import csg_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_req_valid,
    input  logic                 i_req_stall,
    input  logic                 i_opcode,
    input  logic signed [SW-1:0] i_load_value,
    input  logic                 i_res_valid,
    input  logic                 i_res_stall,
    input  logic signed [SW-1:0] i_sample,
    input  logic                 i_psel,
    input  logic                 i_penable,
    input  logic                 i_pwrite,
    input  logic [2:0]           i_paddr,
    input  logic [31:0]          i_pwdata,
    input  logic                 i_pready,
    output int                   o_errors,
    output int                   o_pending
);

    localparam longint UNIT = longint'(1) << FRAC_BITS;
    localparam longint XMAX = (longint'(1) << (FRAC_BITS + 7)) - 1;
    localparam longint XMIN = -(longint'(1) << (FRAC_BITS + 7));
    localparam longint FULL = 10000;

    logic [1:0]  map_mode;
    logic [13:0] map_param;
    longint      x_now;
    longint      x_prev;
    longint      last_sample;
    longint      sample_queue[$];

    function automatic longint clamp_x(longint v);
        if (v > XMAX) return XMAX;
        if (v < XMIN) return XMIN;
        return v;
    endfunction

    function automatic longint clamp_sample(longint v);
        if (v > FULL) return FULL;
        if (v < -FULL) return -FULL;
        return v;
    endfunction

    // magnitude product, truncated toward zero
    function automatic longint fx_mul(longint a, longint b);
        longint ma;
        longint mb;
        longint p;
        ma = a < 0 ? -a : a;
        mb = b < 0 ? -b : b;
        p = (ma * mb) >>> FRAC_BITS;
        return clamp_x(((a < 0) != (b < 0)) ? -p : p);
    endfunction

    function automatic longint param_clamped();
        return map_param > FULL ? FULL : longint'(map_param);
    endfunction

    // rebuild the working value from the last sample
    function automatic void rederive();
        if (map_mode == MODE_HENON) begin
            x_now = clamp_x((last_sample * 3 * UNIT) / (2 * FULL));
        end else if (map_mode == MODE_CELL) begin
            if (last_sample > 255) last_sample = 255;
            if (last_sample < 0) last_sample = 0;
        end else begin
            x_now = clamp_x((last_sample * UNIT) / FULL);
        end
    endfunction

    function automatic longint next_sample();
        longint x;
        longint r;
        longint x3;
        longint n;
        longint s;
        int unsigned cells;
        int unsigned rule;
        int unsigned y;
        int unsigned code;
        int rn;
        int ln;
        x = x_now;
        if (map_mode == MODE_LOGISTIC) begin
            r = 3 * UNIT + (param_clamped() * 9999 * UNIT) / 100000000;
            if (x < 0) x = 0;
            x = fx_mul(fx_mul(x, r), clamp_x(UNIT - x));
            x_now = x;
            s = clamp_sample((x * FULL) / UNIT);
        end else if (map_mode == MODE_CUBIC) begin
            r = 3 * UNIT + (param_clamped() * 9999 * UNIT) / 100000000;
            x3 = fx_mul(fx_mul(x, x), x);
            x = clamp_x(fx_mul(r, x3) + fx_mul(x, clamp_x(UNIT - r)));
            x_now = x;
            s = clamp_sample((x * FULL) / UNIT);
        end else if (map_mode == MODE_HENON) begin
            r = UNIT + (param_clamped() * 4 * UNIT) / 100000;
            n = UNIT - fx_mul(fx_mul(x, x), r) + fx_mul((3 * UNIT) / 10, x_prev);
            // reflect back into +-1.5
            if (n < -(3 * UNIT / 2)) n = -(3 * UNIT / 2) - n;
            if (n > 3 * UNIT / 2) n = 3 * UNIT / 2 - n;
            n = clamp_x(n);
            x_prev = x;
            x_now = n;
            s = clamp_sample((n * 2 * FULL) / (3 * UNIT));
        end else begin
            cells = int'(last_sample) & ((1 << CELL_COUNT) - 1);
            rule = map_param > 255 ? 255 : map_param;
            y = 0;
            for (int i = 0; i < CELL_COUNT; i++) begin
                rn = (i == 0) ? CELL_COUNT - 1 : i - 1;
                ln = (i == CELL_COUNT - 1) ? 0 : i + 1;
                code = ((cells >> rn) & 1) | (((cells >> i) & 1) << 1)
                     | (((cells >> ln) & 1) << 2);
                if ((rule >> code) & 1) y |= 1 << i;
            end
            s = y;
        end
        last_sample = s;
        return s;
    endfunction

    assign o_pending = sample_queue.size();

    always @(posedge i_clk) begin
        longint want;
        if (!i_rst_n) begin
            map_mode = MODE_LOGISTIC;
            map_param = 14'd5000;
            x_now = UNIT / 2;
            x_prev = 0;
            last_sample = 5000;
            sample_queue.delete();
            o_errors = 0;
        end else begin
            if (i_res_valid && !i_res_stall) begin
                if (sample_queue.size() == 0) begin
                    $display("%0t: unexpected sample %0d", $time, i_sample);
                    o_errors++;
                end else begin
                    want = sample_queue.pop_front();
                    if (longint'(i_sample) != want) begin
                        $display("%0t: sample expected %0d actual %0d", $time, want, i_sample);
                        o_errors++;
                    end
                end
            end
            if (i_req_valid && !i_req_stall) begin
                if (i_opcode == OP_LOAD) begin
                    last_sample = clamp_sample(longint'(i_load_value));
                    rederive();
                end else begin
                    sample_queue.push_back(next_sample());
                end
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr == {REG_MODE, 2'b00}) begin
                    map_mode = i_pwdata[1:0];
                    rederive();
                end else if (i_paddr == {REG_PARAM, 2'b00}) begin
                    map_param = i_pwdata[13:0];
                    rederive();
                end
            end
        end
    end

endmodule

// ===== tb/tb_chaotic_sequence_generator_top.sv =====
// stimulus and verdict for the chaotic sequence generator
`timescale 1ns / 1ps

module tb_chaotic_sequence_generator_top;
    import csg_pkg::*;

    localparam int STALL_LIMIT = 4000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic                 i_opcode;
    logic signed [SW-1:0] i_load_value;
    logic                 o_valid;
    logic                 i_stall;
    logic signed [SW-1:0] o_sample;
    logic                 i_psel;
    logic                 i_penable;
    logic                 i_pwrite;
    logic [2:0]           i_paddr;
    logic [31:0]          i_pwdata;
    logic [31:0]          o_prdata;
    logic                 o_pready;
    int                   errors;
    int                   pending;
    int                   idle_cycles;
    bit                   quiet;

    chaotic_sequence_generator_top i_dut (.*);

    csg_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_valid),
        .i_req_stall  (o_stall),
        .i_opcode     (i_opcode),
        .i_load_value (i_load_value),
        .i_res_valid  (o_valid),
        .i_res_stall  (i_stall),
        .i_sample     (o_sample),
        .i_psel       (i_psel),
        .i_penable    (i_penable),
        .i_pwrite     (i_pwrite),
        .i_paddr      (i_paddr),
        .i_pwdata     (i_pwdata),
        .i_pready     (o_pready),
        .o_errors     (errors),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // watchdog on cycles with no request, sample or register write taken
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)
            || (i_psel && i_penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // result side back-pressure
    initial begin
        int n;
        i_stall = 1'b1;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            n = quiet ? 0 : $urandom_range(0, 12);
            if (n > 0) begin
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    task automatic wait_drained();
        while (pending != 0) @(posedge i_clk);
        // a trailing load may still be in flight
        repeat (8) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic sel, input logic [31:0] data);
        wait_drained();
        i_psel <= 1'b1;
        i_pwrite <= 1'b1;
        i_paddr <= {sel, 2'b00};
        i_pwdata <= data;
        @(posedge i_clk);
        i_penable <= 1'b1;
        do @(posedge i_clk); while (!o_pready);
        i_psel <= 1'b0;
        i_penable <= 1'b0;
    endtask

    task automatic send(input logic op, input logic signed [SW-1:0] value);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_opcode <= op;
        i_load_value <= value;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic random_items(input int count);
        int pick;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 78) send(OP_STEP, SW'($urandom));
            else if (pick < 93) send(OP_LOAD, SW'($urandom_range(0, 20000)) - SW'(10000));
            else send(OP_LOAD, SW'($urandom));
        end
    endtask

    initial begin
        logic [1:0]  modes[10]  = '{MODE_LOGISTIC, MODE_LOGISTIC, MODE_CUBIC, MODE_CUBIC,
                                    MODE_HENON, MODE_HENON, MODE_CELL, MODE_CELL,
                                    MODE_CUBIC, MODE_LOGISTIC};
        logic [13:0] params[10] = '{14'd0, 14'd10000, 14'd0, 14'd16383, 14'd10000,
                                    14'd0, 14'd30, 14'd16383, 14'd7321, 14'd9999};
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_opcode = OP_STEP;
        i_load_value = '0;
        i_psel = 1'b0;
        i_penable = 1'b0;
        i_pwrite = 1'b0;
        i_paddr = '0;
        i_pwdata = '0;
        idle_cycles = 0;
        quiet = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset state, saturating loads, negative logistic start
        send(OP_STEP, '0);
        send(OP_STEP, '0);
        send(OP_LOAD, 15'sd16383);
        send(OP_STEP, '0);
        send(OP_LOAD, -15'sd16384);
        send(OP_STEP, '0);
        send(OP_LOAD, -15'sd3000);
        send(OP_STEP, '0);
        send(OP_LOAD, 15'sd0);
        send(OP_STEP, '0);
        i_valid <= 1'b0;
        // hold off until every sample is back
        while (pending != 0) @(posedge i_clk);

        for (int ph = 0; ph < 10; ph++) begin
            quiet = (ph % 3 == 1);
            reg_write(REG_MODE, {30'd0, modes[ph]});
            reg_write(REG_PARAM, {18'd0, params[ph]});
            send(OP_LOAD, 15'sd10000);
            send(OP_STEP, '0);
            send(OP_LOAD, -15'sd10000);
            send(OP_STEP, '0);
            send(OP_LOAD, 15'sd300);
            send(OP_STEP, '0);
            send(OP_LOAD, -15'sd5);
            send(OP_STEP, '0);
            random_items(105);
            i_valid <= 1'b0;
        end
        // cellular rule from a low byte, then back to the reset mode
        reg_write(REG_MODE, {30'd0, MODE_CELL});
        reg_write(REG_PARAM, 32'd110);
        send(OP_LOAD, 15'sd1);
        random_items(20);
        i_valid <= 1'b0;
        reg_write(REG_MODE, {30'd0, MODE_LOGISTIC});
        random_items(10);
        i_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== chaotic_sequence_generator_top.f =====
src/csg_pkg.sv
src/csg_qmul.sv
src/csg_cell.sv
src/chaotic_sequence_generator_top.sv
src/csg_checker.sv
tb/csg_checker.sv
tb/tb_chaotic_sequence_generator_top.sv
